// ===== sv/assert_macros.svh =====
// Assertion macros for the class file carver.
// Included by the top level; expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CCF_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CCF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ccf_pkg.sv =====
// Shared types, constants and the pool tag size table of the class file carver.
// No dependencies; used by the design modules and the testbench.
package ccf_pkg;

  localparam logic [31:0] MAGIC_WORD          = 32'hCAFEBABE;
  localparam logic [31:0] MAX_SIZE_RESET      = 32'd10485760;
  localparam logic [31:0] MEMBER_HEADER_BYTES = 32'd6;
  localparam logic [31:0] CLASS_INFO_BYTES    = 32'd6;
  localparam logic [7:0]  TAG_LIMIT           = 8'd21;

  localparam logic [7:0] TAG_UTF8   = 8'd1;
  localparam logic [7:0] TAG_LONG   = 8'd5;
  localparam logic [7:0] TAG_DOUBLE = 8'd6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [4:0] {
    PH_SCAN       = 5'd0,
    PH_VERSION    = 5'd1,
    PH_POOL_COUNT = 5'd2,
    PH_TAG        = 5'd3,
    PH_CP_BODY    = 5'd4,
    PH_UTF_LEN    = 5'd5,
    PH_UTF_BODY   = 5'd6,
    PH_CLASS_INFO = 5'd7,
    PH_IF_COUNT   = 5'd8,
    PH_IF_BODY    = 5'd9,
    PH_MEM_COUNT  = 5'd10,
    PH_MEM_HDR    = 5'd11,
    PH_MA_COUNT   = 5'd12,
    PH_MA_NAME    = 5'd13,
    PH_MA_LEN     = 5'd14,
    PH_MA_BODY    = 5'd15,
    PH_CA_COUNT   = 5'd16,
    PH_CA_NAME    = 5'd17,
    PH_CA_LEN     = 5'd18,
    PH_CA_BODY    = 5'd19
  } phase_t;

  typedef struct packed {
    logic [47:0] class_offset;
    logic [31:0] class_size;
  } class_rec_t;

  typedef struct packed {
    logic       push;
    class_rec_t rec;
  } q_push_t;

  typedef struct packed {
    logic       valid;
    class_rec_t rec;
  } q_head_t;

  // Body bytes per pool tag; zero marks a tag that is not allowed, or UTF8, whose length is read from the stream.
  function automatic logic [3:0] tag_body_bytes(input logic [7:0] tag);
    logic [3:0] n;
    case (tag)
      8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd17, 8'd18: n = 4'd4;
      8'd5, 8'd6:                                          n = 4'd8;
      8'd7, 8'd8, 8'd16, 8'd19, 8'd20:                     n = 4'd2;
      8'd15:                                               n = 4'd3;
      default:                                             n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/ccf_intf.sv =====
// Channel interfaces of the class file carver: byte stream in, found classes out.
// No dependencies.
interface ccf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ccf_class_if;
  logic        valid;
  logic        ready;
  logic [47:0] class_offset;
  logic [31:0] class_size;

  modport source (output valid, output class_offset, output class_size, input ready);
  modport sink (input valid, input class_offset, input class_size, output ready);
endinterface

// ===== sv/class_file_carver_unit.sv =====
// Top level of the class file carver: parser, candidate queue and output stage.
// Depends on ccf_pkg, ccf_intf, ccf_queue, ccf_front, ccf_back, assert_macros.svh.
//
// Usage:
//   stream carries one image byte per beat (data_byte) with last_byte marking
//   the final byte of an image; the position counter restarts after it.
//   found carries one beat per complete class file: the offset of its magic
//   word and its size in bytes. Classes larger than the size limit are dropped.
//   cfg_wr_en/cfg_wr_data write the size limit; write it only while idle.
// Throughput: one byte per cycle while the queue has room; the parser decides each
//   byte in the cycle it is accepted, including any chain of empty parts that follows.
// Result path: a class is written into the queue when the beat of its last byte
//   is accepted; if within the size limit, it then moves into the output register once that register is free.
// Reset: rst (synchronous) returns to the magic word search at position zero,
//   empties the queue and sets the size limit to 10485760.
// Stall: when found is not taken, results collect in a four-entry queue;
//   stream.ready drops only once that queue is full.
`include "assert_macros.svh"

module class_file_carver_unit
  import ccf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  ccf_byte_if.sink     stream,
  ccf_class_if.source  found
);

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  ccf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .q_push (q_push),
    .q_full (q_full)
  );

  ccf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  ccf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .found       (found)
  );

  `CCF_ASSERT_NOW(a_push_not_full, q_push.push, !q_full, "queue written while full")
  `CCF_ASSERT_NOW(a_push_on_beat, q_push.push, stream.valid && stream.ready, "push without input beat")
  `CCF_ASSERT_NEXT(a_no_spurious_out, !q_head.valid && !found.valid, !found.valid, "result from empty queue")

endmodule

// ===== sv/ccf_queue.sv =====
// Small FIFO of candidate classes between the parser and the output stage.
// Depends on ccf_pkg.
module ccf_queue
  import ccf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  q_push_t q_push,
  output logic    q_full,
  output q_head_t q_head,
  input  logic    q_pop
);

  class_rec_t          mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign q_full       = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign q_head.valid = (count != '0);
  assign q_head.rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem[wr_ptr] <= q_push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({q_push.push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/ccf_front.sv =====
// Byte parser: magic word search and class file walk, one byte per cycle while the queue has room.
// Pushes each completed class into the queue. Depends on ccf_pkg, ccf_intf.
module ccf_front
  import ccf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ccf_byte_if.sink    stream,
  output q_push_t     q_push,
  input  logic        q_full
);

  logic [31:0] window,    window_next;
  phase_t      phase,     phase_next;
  logic [31:0] skip,      skip_next;
  logic [31:0] gather,    gather_next;
  logic [16:0] pool_left, pool_left_next;
  logic [15:0] mem_left,  mem_left_next;
  logic [15:0] attr_left, attr_left_next;
  logic        mpass,     mpass_next;
  logic [31:0] size,      size_next;
  logic [47:0] start,     start_next;
  logic [47:0] pos,       pos_next;

  logic        accept;
  logic [31:0] win_sh;
  logic [31:0] g;
  logic [31:0] skip_dec;
  logic [16:0] pc_left;
  logic [15:0] attr_dec;
  logic [15:0] mem_dec;
  logic [3:0]  tag_bytes;
  logic [16:0] used;
  logic        ma_body_done;
  logic        ca_body_done;
  logic        member_end;
  logic        pass_end;
  logic        finish;

  assign stream.ready = !q_full;
  assign accept       = stream.valid && stream.ready;
  assign win_sh       = {window[23:0], stream.data_byte};
  assign g            = {gather[23:0], stream.data_byte};
  assign skip_dec     = (skip == '0) ? '0 : skip - 32'd1;
  assign pc_left      = {1'b0, g[15:0]} - 17'd1;
  assign attr_dec     = attr_left - 16'd1;
  assign mem_dec      = mem_left - 16'd1;
  assign tag_bytes    = tag_body_bytes(g[7:0]);
  assign used         = ((g[7:0] == TAG_LONG) || (g[7:0] == TAG_DOUBLE)) ? 17'd2 : 17'd1;

  always_comb begin
    window_next    = window;
    phase_next     = phase;
    skip_next      = skip;
    gather_next    = gather;
    pool_left_next = pool_left;
    mem_left_next  = mem_left;
    attr_left_next = attr_left;
    mpass_next     = mpass;
    size_next      = size;
    start_next     = start;
    pos_next       = pos;
    ma_body_done   = 1'b0;
    ca_body_done   = 1'b0;
    member_end     = 1'b0;
    pass_end       = 1'b0;
    finish         = 1'b0;
    q_push.push    = 1'b0;
    q_push.rec     = '0;

    if (accept) begin
      if (phase == PH_SCAN) begin
        window_next = win_sh;
        if (win_sh == MAGIC_WORD) begin
          start_next  = pos - 48'd3;
          size_next   = 32'd4;
          window_next = '0;
          phase_next  = PH_VERSION;
          skip_next   = 32'd4;
          gather_next = '0;
        end
      end else begin
        size_next   = (size == '1) ? size : size + 32'd1;
        gather_next = g;
        skip_next   = skip_dec;
        if (skip_dec == '0) begin
          gather_next = '0;
          case (phase)
            PH_VERSION: begin
              phase_next = PH_POOL_COUNT;
              skip_next  = 32'd2;
            end
            PH_POOL_COUNT: begin
              if (g[15:0] == '0) begin
                phase_next = PH_SCAN;
                skip_next  = '0;
              end else begin
                pool_left_next = pc_left;
                if (pc_left == '0) begin
                  phase_next = PH_CLASS_INFO;
                  skip_next  = CLASS_INFO_BYTES;
                end else begin
                  phase_next = PH_TAG;
                  skip_next  = 32'd1;
                end
              end
            end
            PH_TAG: begin
              if ((g[7:0] != TAG_UTF8) && (g[7:0] >= TAG_LIMIT || tag_bytes == '0)) begin
                phase_next = PH_SCAN;
                skip_next  = '0;
              end else begin
                pool_left_next = (pool_left > used) ? pool_left - used : '0;
                if (g[7:0] == TAG_UTF8) begin
                  phase_next = PH_UTF_LEN;
                  skip_next  = 32'd2;
                end else begin
                  phase_next = PH_CP_BODY;
                  skip_next  = {28'd0, tag_bytes};
                end
              end
            end
            PH_UTF_LEN, PH_CP_BODY, PH_UTF_BODY: begin
              if (phase == PH_UTF_LEN && g[15:0] != '0) begin
                phase_next = PH_UTF_BODY;
                skip_next  = {16'd0, g[15:0]};
              end else if (pool_left == '0) begin
                phase_next = PH_CLASS_INFO;
                skip_next  = CLASS_INFO_BYTES;
              end else begin
                phase_next = PH_TAG;
                skip_next  = 32'd1;
              end
            end
            PH_CLASS_INFO: begin
              phase_next = PH_IF_COUNT;
              skip_next  = 32'd2;
            end
            PH_IF_COUNT, PH_IF_BODY: begin
              if (phase == PH_IF_COUNT && g[15:0] != '0) begin
                phase_next = PH_IF_BODY;
                skip_next  = {15'd0, g[15:0], 1'b0};
              end else begin
                mpass_next = 1'b0;
                phase_next = PH_MEM_COUNT;
                skip_next  = 32'd2;
              end
            end
            PH_MEM_COUNT: begin
              mem_left_next = g[15:0];
              if (g[15:0] == '0) begin
                pass_end = 1'b1;
              end else begin
                phase_next = PH_MEM_HDR;
                skip_next  = MEMBER_HEADER_BYTES;
              end
            end
            PH_MEM_HDR: begin
              phase_next = PH_MA_COUNT;
              skip_next  = 32'd2;
            end
            PH_MA_COUNT: begin
              attr_left_next = g[15:0];
              if (g[15:0] == '0) begin
                member_end = 1'b1;
              end else begin
                phase_next = PH_MA_NAME;
                skip_next  = 32'd2;
              end
            end
            PH_MA_NAME: begin
              phase_next = PH_MA_LEN;
              skip_next  = 32'd4;
            end
            PH_MA_LEN: begin
              if (g == '0) begin
                ma_body_done = 1'b1;
              end else begin
                phase_next = PH_MA_BODY;
                skip_next  = g;
              end
            end
            PH_MA_BODY: begin
              ma_body_done = 1'b1;
            end
            PH_CA_COUNT: begin
              attr_left_next = g[15:0];
              if (g[15:0] == '0) begin
                finish = 1'b1;
              end else begin
                phase_next = PH_CA_NAME;
                skip_next  = 32'd2;
              end
            end
            PH_CA_NAME: begin
              phase_next = PH_CA_LEN;
              skip_next  = 32'd4;
            end
            PH_CA_LEN: begin
              if (g == '0) begin
                ca_body_done = 1'b1;
              end else begin
                phase_next = PH_CA_BODY;
                skip_next  = g;
              end
            end
            PH_CA_BODY: begin
              ca_body_done = 1'b1;
            end
            default: begin
              phase_next = PH_SCAN;
              skip_next  = '0;
            end
          endcase

          // Resolve zero-length follow-ups within the same beat.
          if (ma_body_done) begin
            attr_left_next = attr_dec;
            if (attr_dec == '0) begin
              member_end = 1'b1;
            end else begin
              phase_next = PH_MA_NAME;
              skip_next  = 32'd2;
            end
          end
          if (member_end) begin
            mem_left_next = mem_dec;
            if (mem_dec == '0) begin
              pass_end = 1'b1;
            end else begin
              phase_next = PH_MEM_HDR;
              skip_next  = MEMBER_HEADER_BYTES;
            end
          end
          if (pass_end) begin
            skip_next = 32'd2;
            if (!mpass) begin
              mpass_next = 1'b1;
              phase_next = PH_MEM_COUNT;
            end else begin
              phase_next = PH_CA_COUNT;
            end
          end
          if (ca_body_done) begin
            attr_left_next = attr_dec;
            if (attr_dec == '0) begin
              finish = 1'b1;
            end else begin
              phase_next = PH_CA_NAME;
              skip_next  = 32'd2;
            end
          end
          if (finish) begin
            q_push.push             = 1'b1;
            q_push.rec.class_offset = start;
            q_push.rec.class_size   = size_next;
            phase_next              = PH_SCAN;
            skip_next               = '0;
            window_next             = '0;
          end
        end
      end

      if (stream.last_byte) begin
        phase_next  = PH_SCAN;
        skip_next   = '0;
        gather_next = '0;
        window_next = '0;
        pos_next    = '0;
      end else begin
        pos_next = pos + 48'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      phase     <= PH_SCAN;
      skip      <= '0;
      gather    <= '0;
      pool_left <= '0;
      mem_left  <= '0;
      attr_left <= '0;
      mpass     <= 1'b0;
      size      <= '0;
      start     <= '0;
      pos       <= '0;
    end else begin
      window    <= window_next;
      phase     <= phase_next;
      skip      <= skip_next;
      gather    <= gather_next;
      pool_left <= pool_left_next;
      mem_left  <= mem_left_next;
      attr_left <= attr_left_next;
      mpass     <= mpass_next;
      size      <= size_next;
      start     <= start_next;
      pos       <= pos_next;
    end
  end

endmodule

// ===== sv/ccf_back.sv =====
// Output stage: holds the size limit, drops oversized classes, drives results.
// Depends on ccf_pkg, ccf_intf.
module ccf_back
  import ccf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  q_head_t      q_head,
  output logic         q_pop,
  ccf_class_if.source  found
);

  logic       [31:0] max_size;
  logic              out_valid;
  class_rec_t        out_rec;
  logic              slot_free;
  logic              fits;

  assign slot_free = !out_valid || found.ready;
  assign fits      = (q_head.rec.class_size <= max_size);
  assign q_pop     = q_head.valid && slot_free;

  assign found.valid        = out_valid;
  assign found.class_offset = out_rec.class_offset;
  assign found.class_size   = out_rec.class_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size  <= MAX_SIZE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_size <= cfg_wr_data;
      end
      if (slot_free) begin
        out_valid <= q_head.valid && fits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && fits) begin
      out_rec <= q_head.rec;
    end
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for class_file_carver_unit: byte images in, found classes out.
// A directed table, then random class images; each found class is checked in order.
// Depends on ccf_pkg, ccf_intf and the RTL of the unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ccf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic        hit;
    logic [47:0] offset;
    logic [31:0] size;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam logic [3:0] BODY_BYTES [0:20] =
    '{4'd0, 4'd0, 4'd0, 4'd4, 4'd4, 4'd8, 4'd8, 4'd2, 4'd2, 4'd4, 4'd4,
      4'd4, 4'd4, 4'd0, 4'd0, 4'd3, 4'd2, 4'd4, 4'd4, 4'd2, 4'd2};
  localparam logic [7:0] GOOD_TAGS [0:16] =
    '{8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12,
      8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20};
  localparam logic [7:0] BAD_TAGS [0:3] = '{8'd0, 8'd2, 8'd13, 8'd14};

  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{8'hCA, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'hFE, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'hBA, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'hBE, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h34, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h01, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h21, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h02, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h03, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b1, 1'b1, 1'b1, 48'd0, 32'd24},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 48'd0, 32'd0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 48'd0, 32'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        src_valid = 1'b0;
  logic [7:0]  src_data = '0;
  logic        src_last = 1'b0;
  logic        snk_ready = 1'b0;
  logic        snk_hold = 1'b0;
  logic        hold_go = 1'b0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned err_count = 0;

  beat_t       byte_backlog [$];
  class_rec_t  pending_classes [$];
  logic [7:0]  image_q [$];
  beat_t       next_beat;
  class_rec_t  want;

  // predictor state
  logic [31:0] max_size;
  logic [31:0] win;
  phase_t      ph;
  logic [31:0] skip_left;
  logic [31:0] gather;
  logic [16:0] pool_left;
  logic [15:0] members_left;
  logic [15:0] attrs_left;
  logic        in_methods;
  logic [31:0] class_len;
  logic [47:0] class_start;
  logic [47:0] pos;
  logic        found_flag;

  ccf_byte_if  stream_if();
  ccf_class_if found_if();

  assign stream_if.valid     = src_valid;
  assign stream_if.data_byte = src_data;
  assign stream_if.last_byte = src_last;
  assign found_if.ready      = snk_ready;

  class_file_carver_unit uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .stream     (stream_if),
    .found      (found_if)
  );

  always #5 clk = ~clk;

  task automatic enter_phase(input phase_t p, input logic [31:0] n);
    ph = p;
    skip_left = n;
    gather = '0;
  endtask

  task automatic abandon_parse();
    enter_phase(PH_SCAN, '0);
    win = '0;
  endtask

  task automatic close_class();
    if (class_len <= max_size) found_flag = 1'b1;
    abandon_parse();
  endtask

  task automatic next_pool_entry();
    if (pool_left == 0) enter_phase(PH_CLASS_INFO, CLASS_INFO_BYTES);
    else enter_phase(PH_TAG, 32'd1);
  endtask

  task automatic end_member_pass();
    if (!in_methods) begin
      in_methods = 1'b1;
      enter_phase(PH_MEM_COUNT, 32'd2);
    end else begin
      enter_phase(PH_CA_COUNT, 32'd2);
    end
  endtask

  task automatic end_member();
    members_left = members_left - 16'd1;
    if (members_left == 0) end_member_pass();
    else enter_phase(PH_MEM_HDR, MEMBER_HEADER_BYTES);
  endtask

  task automatic carve_reset();
    max_size = MAX_SIZE_RESET;
    win = '0;
    ph = PH_SCAN;
    skip_left = '0;
    gather = '0;
    pool_left = '0;
    members_left = '0;
    attrs_left = '0;
    in_methods = 1'b0;
    class_len = '0;
    class_start = '0;
    pos = '0;
    found_flag = 1'b0;
  endtask

  task automatic carve_byte(input logic [7:0] b, input logic l,
                            output logic hit, output class_rec_t rec);
    logic [7:0]  tag;
    logic [16:0] used;
    found_flag = 1'b0;
    if (ph == PH_SCAN) begin
      win = {win[23:0], b};
      if (win == MAGIC_WORD) begin
        class_start = pos - 48'd3;
        class_len = 32'd4;
        win = '0;
        enter_phase(PH_VERSION, 32'd4);
      end
    end else begin
      if (class_len != '1) class_len = class_len + 32'd1;
      gather = {gather[23:0], b};
      if (skip_left != 0) skip_left = skip_left - 32'd1;
      while (ph != PH_SCAN && skip_left == 0) begin
        case (ph)
          PH_VERSION: enter_phase(PH_POOL_COUNT, 32'd2);
          PH_POOL_COUNT: begin
            if (gather[15:0] == 0) begin
              abandon_parse();
            end else begin
              pool_left = 17'(gather[15:0]) - 17'd1;
              next_pool_entry();
            end
          end
          PH_TAG: begin
            tag = gather[7:0];
            if (tag != TAG_UTF8 && tag >= TAG_LIMIT) begin
              abandon_parse();
            end else if (tag != TAG_UTF8 && BODY_BYTES[tag] == 0) begin
              abandon_parse();
            end else begin
              used = (tag == TAG_LONG || tag == TAG_DOUBLE) ? 17'd2 : 17'd1;
              pool_left = (pool_left > used) ? pool_left - used : '0;
              if (tag == TAG_UTF8) enter_phase(PH_UTF_LEN, 32'd2);
              else enter_phase(PH_CP_BODY, 32'(BODY_BYTES[tag]));
            end
          end
          PH_UTF_LEN: enter_phase(PH_UTF_BODY, 32'(gather[15:0]));
          PH_CP_BODY, PH_UTF_BODY: next_pool_entry();
          PH_CLASS_INFO: enter_phase(PH_IF_COUNT, 32'd2);
          PH_IF_COUNT: enter_phase(PH_IF_BODY, {15'd0, gather[15:0], 1'b0});
          PH_IF_BODY: begin
            in_methods = 1'b0;
            enter_phase(PH_MEM_COUNT, 32'd2);
          end
          PH_MEM_COUNT: begin
            members_left = gather[15:0];
            if (members_left == 0) end_member_pass();
            else enter_phase(PH_MEM_HDR, MEMBER_HEADER_BYTES);
          end
          PH_MEM_HDR: enter_phase(PH_MA_COUNT, 32'd2);
          PH_MA_COUNT: begin
            attrs_left = gather[15:0];
            if (attrs_left == 0) end_member();
            else enter_phase(PH_MA_NAME, 32'd2);
          end
          PH_MA_NAME: enter_phase(PH_MA_LEN, 32'd4);
          PH_MA_LEN: enter_phase(PH_MA_BODY, gather);
          PH_MA_BODY: begin
            attrs_left = attrs_left - 16'd1;
            if (attrs_left == 0) end_member();
            else enter_phase(PH_MA_NAME, 32'd2);
          end
          PH_CA_COUNT: begin
            attrs_left = gather[15:0];
            if (attrs_left == 0) close_class();
            else enter_phase(PH_CA_NAME, 32'd2);
          end
          PH_CA_NAME: enter_phase(PH_CA_LEN, 32'd4);
          PH_CA_LEN: enter_phase(PH_CA_BODY, gather);
          PH_CA_BODY: begin
            attrs_left = attrs_left - 16'd1;
            if (attrs_left == 0) close_class();
            else enter_phase(PH_CA_NAME, 32'd2);
          end
          default: abandon_parse();
        endcase
      end
    end
    hit = found_flag;
    rec.class_offset = class_start;
    rec.class_size = class_len;
    if (l) begin
      abandon_parse();
      pos = '0;
    end else begin
      pos = pos + 48'd1;
    end
  endtask

  task automatic queue_beat(input logic [7:0] b, input logic l,
                            output logic hit, output class_rec_t rec);
    carve_byte(b, l, hit, rec);
    byte_backlog.push_back('{data: b, last: l});
  endtask

  task automatic put8(input logic [7:0] v);
    image_q.push_back(v);
  endtask

  task automatic put16(input logic [15:0] v);
    put8(v[15:8]);
    put8(v[7:0]);
  endtask

  task automatic put32(input logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endtask

  task automatic put_rand(input int unsigned n);
    repeat (n) put8(8'($urandom));
  endtask

  task automatic put_attrs();
    int unsigned n;
    int unsigned len;
    n = $urandom_range(2);
    put16(16'(n));
    repeat (n) begin
      put_rand(2);
      len = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(4);
      put32(32'(len));
      put_rand(len);
    end
  endtask

  task automatic put_members();
    int unsigned n;
    n = $urandom_range(2);
    put16(16'(n));
    repeat (n) begin
      put_rand(MEMBER_HEADER_BYTES);
      put_attrs();
    end
  endtask

  task automatic send_sequence(output int unsigned sent, output int unsigned hits);
    int unsigned kind;
    int unsigned slots;
    int unsigned bad_at;
    int unsigned entry;
    int unsigned n;
    int unsigned cut;
    int unsigned len;
    logic        trunc;
    logic        l;
    logic [7:0]  tag;
    logic        hit;
    class_rec_t  rec;
    image_q.delete();
    hits = 0;
    kind = $urandom_range(99);
    put_rand($urandom_range(3));
    put32(MAGIC_WORD);
    put_rand(4);
    if (kind < 6) begin
      put16(16'd0);
    end else begin
      slots = (kind < 60) ? $urandom_range(3) : $urandom_range(8);
      bad_at = (kind < 16 && slots != 0) ? $urandom_range(slots - 1) : 32'hFFFF_FFFF;
      put16(16'(slots + 1));
      entry = 0;
      while (slots != 0) begin
        tag = GOOD_TAGS[$urandom_range(16)];
        if (entry == bad_at) begin
          if ($urandom_range(4) == 0) tag = 8'($urandom_range(255, 21));
          else tag = BAD_TAGS[$urandom_range(3)];
        end
        put8(tag);
        if (tag == TAG_UTF8) begin
          len = ($urandom_range(15) == 0) ? $urandom_range(300) : $urandom_range(5);
          put16(16'(len));
          put_rand(len);
        end else if (tag < TAG_LIMIT) begin
          put_rand(BODY_BYTES[tag]);
        end
        if ((tag == TAG_LONG || tag == TAG_DOUBLE) && slots >= 2) slots = slots - 2;
        else slots = slots - 1;
        entry++;
      end
      put_rand(CLASS_INFO_BYTES);
      n = $urandom_range(2);
      put16(16'(n));
      put_rand(2 * n);
      put_members();
      put_members();
      put_attrs();
    end
    cut = image_q.size() - 1;
    trunc = 1'b0;
    if (kind >= 16 && kind < 24) begin
      cut = $urandom_range(image_q.size() - 1);
      trunc = 1'b1;
    end else if ($urandom_range(9) == 0) begin
      trunc = 1'b1;
    end
    while (image_q.size() > cut + 1) void'(image_q.pop_back());
    put_rand($urandom_range(2));
    for (int i = 0; i < image_q.size(); i++) begin
      if (i > cut) l = ($urandom_range(7) == 0);
      else l = trunc && (i == cut);
      queue_beat(image_q[i], l, hit, rec);
      if (hit) begin
        pending_classes.push_back(rec);
        hits++;
      end
    end
    sent = cut + 1;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (byte_backlog.size() != 0 || src_valid || pending_classes.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input logic [31:0] limit, input int unsigned min_bytes,
                           input int unsigned min_classes, input logic squeeze);
    int unsigned bytes;
    int unsigned classes;
    int unsigned s;
    int unsigned h;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_size = limit;
    bytes = 0;
    classes = 0;
    while (bytes < min_bytes || classes < min_classes) begin
      send_sequence(s, h);
      bytes += s;
      classes += h;
    end
    if (squeeze) hold_go = 1'b1;
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (!src_valid || stream_if.ready) begin
      if (byte_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_beat = byte_backlog.pop_front();
        src_valid <= 1'b1;
        src_data <= next_beat.data;
        src_last <= next_beat.last;
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      snk_ready <= 1'b0;
    end else begin
      if (found_if.valid && snk_ready) begin
        if (pending_classes.size() == 0) begin
          $error("class with no expectation: class_offset %0h class_size %0d",
                 found_if.class_offset, found_if.class_size);
          err_count++;
        end else begin
          want = pending_classes.pop_front();
          if (found_if.class_offset !== want.class_offset) begin
            $error("class_offset: expected %0h, actual %0h",
                   want.class_offset, found_if.class_offset);
            err_count++;
          end
          if (found_if.class_size !== want.class_size) begin
            $error("class_size: expected %0d, actual %0d",
                   want.class_size, found_if.class_size);
            err_count++;
          end
        end
      end
      snk_ready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // hold off the result side long enough to fill the queue and stall the stream
  initial begin
    wait (hold_go);
    @(posedge clk);
    snk_hold <= 1'b1;
    repeat (300) @(posedge clk);
    snk_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("** class_file_carver_unit: FAILED **");
    $finish;
  end

  initial begin
    logic       hit;
    class_rec_t rec;
    carve_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      queue_beat(dir_tab[i].data, dir_tab[i].last, hit, rec);
      if (dir_tab[i].typed) begin
        if (dir_tab[i].hit)
          pending_classes.push_back('{class_offset: dir_tab[i].offset,
                                      class_size: dir_tab[i].size});
      end else if (hit) begin
        pending_classes.push_back(rec);
      end
    end
    wait_drained();
    run_phase(7, 49, 32'hFFFF_FFFF, 200, 15, 1'b1);
    run_phase(7, 49, 32'd0, 60, 0, 1'b0);
    run_phase(49, 7, 32'($urandom_range(48, 28)), 200, 12, 1'b0);
    run_phase(0, 0, MAX_SIZE_RESET, 200, 15, 1'b0);
    if (pending_classes.size() != 0)
      $error("%0d expected classes never arrived", pending_classes.size());
    if (err_count == 0 && pending_classes.size() == 0) begin
      $display("** class_file_carver_unit: PASSED **");
    end else begin
      $display("** class_file_carver_unit: FAILED **");
    end
    $finish;
  end

endmodule
